// File: rtl/core/exp_taylor_series_defines.svh
// -----------------------------------------------------------------------------
// exp_taylor_series_defines
// Assertion macros shared by the exponential series block.
// -----------------------------------------------------------------------------
`ifndef EXP_TAYLOR_SERIES_DEFINES_SVH
`define EXP_TAYLOR_SERIES_DEFINES_SVH

// same-cycle implication, checked out of reset only
`define ETX_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("etx: same-cycle check failed");

// next-cycle implication
`define ETX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("etx: next-cycle check failed");

`endif

// File: rtl/core/etx_pkg.sv
// -----------------------------------------------------------------------------
// etx_pkg
// Widths, constants and types of the exponential series block.
// -----------------------------------------------------------------------------
`default_nettype none

package etx_pkg;

    localparam int X_W        = 16;   // argument width
    localparam int EXP_W      = 32;   // result width
    localparam int TC_W       = 5;    // term count width
    localparam int MAX_TERMS  = 31;
    localparam int TC_RESET   = 12;
    localparam int IN_FRAC    = 12;   // fraction bits of the argument
    localparam int ACC_FRAC   = 24;   // fraction bits of terms and sum
    localparam int OUT_FRAC   = 16;
    localparam int OUT_SHIFT  = ACC_FRAC - OUT_FRAC;

    // term magnitude is clipped to 2^47, so 48 bits hold it
    localparam int TERM_MAG_W = 48;
    localparam int PROD_W     = TERM_MAG_W + X_W;
    // product magnitude <= 2^62, after dropping IN_FRAC bits
    localparam int QUO_W      = PROD_W - 1 - IN_FRAC;
    localparam int SUM_W      = TERM_MAG_W + TC_W + 1;

    // divider: bits retired per cycle and resulting cycle count
    localparam int DIV_STEP   = 8;
    localparam int DIV_CYC    = (QUO_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_PAD_W  = DIV_CYC * DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYC);

    localparam logic [TERM_MAG_W-1:0] TERM_ONE = TERM_MAG_W'(64'd1 << ACC_FRAC);
    localparam logic [TERM_MAG_W-1:0] TERM_LIM = TERM_MAG_W'(64'd1 << (TERM_MAG_W - 1));
    localparam logic [SUM_W-1:0]      SUM_ONE  = SUM_W'(64'd1 << ACC_FRAC);
    localparam logic [SUM_W-1:0]      RND_ADJ  = SUM_W'((64'd1 << OUT_SHIFT) - 64'd1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// File: rtl/core/etx_mul.sv
// -----------------------------------------------------------------------------
// etx_mul
// Registered unsigned multiply of term magnitude by argument magnitude.
// -----------------------------------------------------------------------------
`default_nettype none

module etx_mul (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [etx_pkg::TERM_MAG_W-1:0] i_a,
    input  wire logic [etx_pkg::X_W-1:0]        i_b,
    output logic      [etx_pkg::PROD_W-1:0]     o_p
);

    logic [etx_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= etx_pkg::PROD_W'(i_a) * etx_pkg::PROD_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: rtl/core/etx_div.sv
// -----------------------------------------------------------------------------
// etx_div
// Iterative restoring divide by a small integer, DIV_STEP bits per cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module etx_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [etx_pkg::QUO_W-1:0] i_dividend,
    input  wire logic [etx_pkg::TC_W-1:0]  i_divisor,
    output logic      [etx_pkg::QUO_W-1:0] o_quotient,
    output etx_pkg::t_div_stat             o_stat
);

    logic [etx_pkg::DIV_PAD_W-1:0] r_num, n_num;
    logic [etx_pkg::DIV_PAD_W-1:0] r_quo;
    logic [etx_pkg::TC_W-1:0]      r_rem, n_rem;
    logic [etx_pkg::TC_W-1:0]      r_dvs;
    logic [etx_pkg::DIV_STEP-1:0]  n_qbits;
    logic [etx_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    // one chunk of long division; remainder stays below the divisor
    always_comb begin
        logic [etx_pkg::TC_W:0] t;
        n_num   = r_num;
        n_rem   = r_rem;
        n_qbits = '0;
        for (int i = 0; i < etx_pkg::DIV_STEP; i++) begin
            t     = {n_rem, n_num[etx_pkg::DIV_PAD_W-1]};
            n_num = {n_num[etx_pkg::DIV_PAD_W-2:0], 1'b0};
            if (t >= {1'b0, r_dvs}) begin
                n_rem   = etx_pkg::TC_W'(t - {1'b0, r_dvs});
                n_qbits = {n_qbits[etx_pkg::DIV_STEP-2:0], 1'b1};
            end else begin
                n_rem   = etx_pkg::TC_W'(t);
                n_qbits = {n_qbits[etx_pkg::DIV_STEP-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= etx_pkg::DIV_PAD_W'(i_dividend);
            r_quo <= '0;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= {r_quo[etx_pkg::DIV_PAD_W-etx_pkg::DIV_STEP-1:0], n_qbits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == etx_pkg::DIV_CNT_W'(etx_pkg::DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient  = r_quo[etx_pkg::QUO_W-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// File: rtl/core/exp_taylor_series.sv
// -----------------------------------------------------------------------------
// exp_taylor_series
// Truncated Maclaurin series of exp(x), Q4.12 in, saturated Q16.16 out.
// -----------------------------------------------------------------------------
// Input stream: s_axis tdata carries x (signed Q4.12). One request in,
// one result out: m_axis tdata is the sum 1 + x + ... + x^N/N! (signed
// Q16.16), tuser bit 0 flags that the result or a term was clipped.
// N comes from the term count register (5 bits, reset 12), written through
// i_cfg_wr_en / i_cfg_wr_data. The user must write it only while no
// request is in flight; the block itself does not enforce this. Each
// term runs through one multiply into a registered product, one
// divider load, the shared divide-by-k unit, which retires 8 quotient
// bits a cycle, and a last step to clip and accumulate. One request is
// worked on at a time, until its result is in the output register.
// The result sits in an output register, so a new request is taken while
// it waits; a stalled receiver only holds up the following result.
// Reset (synchronous, active low) empties the output, returns the
// sequencer to idle and sets the term count back to 12.
// -----------------------------------------------------------------------------
`default_nettype none

`include "exp_taylor_series_defines.svh"

module exp_taylor_series (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [etx_pkg::TC_W-1:0]  i_cfg_wr_data,   // term_count
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  wire logic [etx_pkg::X_W-1:0]   i_s_axis_tdata,  // [15:0] x_value
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    output logic      [etx_pkg::EXP_W-1:0] o_m_axis_tdata,  // [31:0] exp_value
    output logic      [0:0]                o_m_axis_tuser   // [0] saturated
);

    etx_pkg::t_state                   r_state;
    logic [etx_pkg::TC_W-1:0]          r_term_count;
    logic [etx_pkg::TC_W-1:0]          r_n;
    logic [etx_pkg::TC_W-1:0]          r_k;
    logic [etx_pkg::TC_W-1:0]          n_cnt;
    logic                              r_x_neg;
    logic [etx_pkg::X_W-1:0]           r_x_mag;
    logic                              r_t_neg;
    logic [etx_pkg::TERM_MAG_W-1:0]    r_t_mag, n_t_mag;
    logic signed [etx_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic signed [etx_pkg::SUM_W-1:0]  term_sv;
    logic signed [etx_pkg::SUM_W-1:0]  sum_adj, sum_q;
    logic                              r_sat;
    logic                              term_clip;
    logic                              out_clip;
    logic [etx_pkg::EXP_W-1:0]         out_val;
    logic                              r_out_valid;
    logic [etx_pkg::EXP_W-1:0]         r_out_data;
    logic                              r_out_sat;
    logic                              s_accept;
    logic                              out_load;
    logic [etx_pkg::X_W-1:0]           x_abs;

    logic [etx_pkg::PROD_W-1:0]        prod;
    logic [etx_pkg::QUO_W-1:0]         quo;
    etx_pkg::t_div_stat                div_stat;

    etx_mul u_mul (
        .i_clk (i_clk),
        .i_en  (r_state == etx_pkg::S_MUL),
        .i_a   (r_t_mag),
        .i_b   (r_x_mag),
        .o_p   (prod)
    );

    // product >> IN_FRAC, then the divide by k
    etx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == etx_pkg::S_DIV),
        .i_dividend (prod[etx_pkg::PROD_W-2:etx_pkg::IN_FRAC]),
        .i_divisor  (r_k),
        .o_quotient (quo),
        .o_stat     (div_stat)
    );

    assign o_s_axis_tready = (r_state == etx_pkg::S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == etx_pkg::S_OUT) && (!r_out_valid || i_m_axis_tready);

    assign x_abs = i_s_axis_tdata[etx_pkg::X_W-1] ? (~i_s_axis_tdata + 1'b1) : i_s_axis_tdata;
    assign n_cnt = (r_term_count > etx_pkg::TC_W'(etx_pkg::MAX_TERMS))
                 ? etx_pkg::TC_W'(etx_pkg::MAX_TERMS) : r_term_count;

    // term update: clip at 2^47, then add with the sign of term * x
    always_comb begin
        term_clip = quo > etx_pkg::QUO_W'(etx_pkg::TERM_LIM);
        n_t_mag   = term_clip ? etx_pkg::TERM_LIM : quo[etx_pkg::TERM_MAG_W-1:0];
        term_sv   = etx_pkg::SUM_W'(n_t_mag);
        n_sum     = (r_t_neg ^ r_x_neg) ? (r_sum - term_sv) : (r_sum + term_sv);
    end

    // Q.24 to Q.16, truncating toward zero, then saturate to 32 bits
    always_comb begin
        sum_adj  = r_sum[etx_pkg::SUM_W-1] ? (r_sum + etx_pkg::RND_ADJ) : r_sum;
        sum_q    = sum_adj >>> etx_pkg::OUT_SHIFT;
        out_clip = !((&sum_q[etx_pkg::SUM_W-1:etx_pkg::EXP_W-1])
                   || (~|sum_q[etx_pkg::SUM_W-1:etx_pkg::EXP_W-1]));
        if (!out_clip) begin
            out_val = sum_q[etx_pkg::EXP_W-1:0];
        end else if (sum_q[etx_pkg::SUM_W-1]) begin
            out_val = {1'b1, {(etx_pkg::EXP_W-1){1'b0}}};
        end else begin
            out_val = {1'b0, {(etx_pkg::EXP_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= etx_pkg::S_IDLE;
            r_term_count <= etx_pkg::TC_W'(etx_pkg::TC_RESET);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_term_count <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                etx_pkg::S_IDLE: begin
                    if (s_accept) begin
                        r_state <= (n_cnt == '0) ? etx_pkg::S_OUT : etx_pkg::S_MUL;
                    end
                end
                etx_pkg::S_MUL: begin
                    r_state <= etx_pkg::S_DIV;
                end
                etx_pkg::S_DIV: begin
                    r_state <= etx_pkg::S_WAIT;
                end
                etx_pkg::S_WAIT: begin
                    if (div_stat.done) begin
                        r_state <= (r_k == r_n) ? etx_pkg::S_OUT : etx_pkg::S_MUL;
                    end
                end
                etx_pkg::S_OUT: begin
                    if (out_load) begin
                        r_state <= etx_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= etx_pkg::S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x_neg <= i_s_axis_tdata[etx_pkg::X_W-1];
            r_x_mag <= x_abs;
            r_n     <= n_cnt;
            r_k     <= etx_pkg::TC_W'(1);
            r_t_neg <= 1'b0;
            r_t_mag <= etx_pkg::TERM_ONE;
            r_sum   <= etx_pkg::SUM_ONE;
            r_sat   <= 1'b0;
        end else if ((r_state == etx_pkg::S_WAIT) && div_stat.done) begin
            r_t_neg <= r_t_neg ^ r_x_neg;
            r_t_mag <= n_t_mag;
            r_sum   <= n_sum;
            r_sat   <= r_sat | term_clip;
            r_k     <= r_k + 1'b1;
        end
        if (out_load) begin
            r_out_data <= out_val;
            r_out_sat  <= r_sat | out_clip;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_sat;

    `ETX_ASSERT_NEXT(a_accept_starts, (i_s_axis_tvalid && o_s_axis_tready), (r_state == etx_pkg::S_MUL || r_state == etx_pkg::S_OUT))
    `ETX_ASSERT_IMPL(a_done_in_wait, div_stat.done, r_state == etx_pkg::S_WAIT)
    `ETX_ASSERT_IMPL(a_wait_has_div, r_state == etx_pkg::S_WAIT, div_stat.busy || div_stat.done)
    `ETX_ASSERT_IMPL(a_k_in_range, r_state == etx_pkg::S_MUL, r_k != '0 && r_k <= r_n)

endmodule

`default_nettype wire

// File: bench/exp_taylor_series_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_taylor_series_test
// Self-checking bench for the exponential series block: a short table of
// edge arguments and term counts, then random arguments over many term-count
// settings, each result compared with a table value or bit-exact predictor.
// ----------------------------------------------------------------------------

module exp_taylor_series_test;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PHASES       = 20;
    localparam int PER_PHASE    = 94;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 10 * etx_pkg::MAX_TERMS + 90;
    localparam int IDLE_PERCENT = 13;

    typedef struct packed {
        logic [etx_pkg::EXP_W-1:0] value;
        logic                      clipped;
    } t_sum;

    // one row of the directed table
    typedef struct packed {
        logic [etx_pkg::TC_W-1:0] terms;
        logic [etx_pkg::X_W-1:0]  x;
        logic                     typed;     // expected sum written in the row
        t_sum                     want;
    } t_vec;

    // what the sender knows about each request it offers
    typedef struct packed {
        logic typed;
        t_sum want;
    } t_note;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [etx_pkg::TC_W-1:0]   i_cfg_wr_data = '0;
    logic                       i_s_axis_tvalid = 1'b0;
    logic                       o_s_axis_tready;
    logic [etx_pkg::X_W-1:0]    i_s_axis_tdata = '0;
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready = 1'b0;
    logic [etx_pkg::EXP_W-1:0]  o_m_axis_tdata;
    logic [0:0]                 o_m_axis_tuser;

    t_vec                       dir_table[$];
    t_note                      sent_notes[$];
    t_sum                       pending_sums[$];
    logic [etx_pkg::TC_W-1:0]   term_reg = etx_pkg::TC_W'(etx_pkg::TC_RESET);
    bit                         steady = 1'b0;
    bit                         hold_go = 1'b0;
    bit                         hold_done = 1'b0;
    int                         hold_left = 0;
    int                         x_sent = 0;
    int                         sums_checked = 0;
    int                         fail_count = 0;
    int                         cfg_writes = 0;
    int                         cycle_cnt = 0;
    t_sum                       got_sum;
    t_sum                       exp_sum;
    t_note                      acc_note;

    exp_taylor_series u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // 1 + x + ... + x^n/n!, each term truncated toward zero in Q.24
    function automatic t_sum series_exp(input logic [etx_pkg::X_W-1:0] xv,
                                        input logic [etx_pkg::TC_W-1:0] n);
        longint xs;
        longint term;
        longint total;
        longint q16;
        longint lim;
        int     last;
        t_sum   r;
        xs    = longint'($signed(xv));
        term  = longint'(1) << etx_pkg::ACC_FRAC;
        total = term;
        lim   = longint'(1) << (etx_pkg::TERM_MAG_W - 1);
        last  = (int'(n) > etx_pkg::MAX_TERMS) ? etx_pkg::MAX_TERMS : int'(n);
        r.clipped = 1'b0;
        for (int k = 1; k <= last; k++) begin
            term = (term * xs) / (longint'(k) << etx_pkg::IN_FRAC);
            if (term > lim) begin
                term = lim;
                r.clipped = 1'b1;
            end else if (term < -lim) begin
                term = -lim;
                r.clipped = 1'b1;
            end
            total += term;
        end
        q16 = total / (longint'(1) << etx_pkg::OUT_SHIFT);
        if (q16 > longint'(32'sh7FFF_FFFF)) begin
            q16 = longint'(32'sh7FFF_FFFF);
            r.clipped = 1'b1;
        end else if (q16 < -(longint'(1) << 31)) begin
            q16 = -(longint'(1) << 31);
            r.clipped = 1'b1;
        end
        r.value = q16[etx_pkg::EXP_W-1:0];
        return r;
    endfunction

    function automatic logic [etx_pkg::X_W-1:0] rand_x();
        logic [etx_pkg::X_W-1:0] m;
        logic [etx_pkg::X_W-1:0] picks[7];
        picks = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h1000, 16'hF000};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return etx_pkg::X_W'($urandom);
            5, 6, 7: begin
                m = etx_pkg::X_W'($urandom_range(0, 16'h1FFF));
                return $urandom_range(0, 1) ? -m : m;
            end
            8: return picks[$urandom_range(0, 6)];
            // near a whole number, where truncation effects pile up
            default: return etx_pkg::X_W'((int'($urandom_range(0, 15)) - 8) * 4096
                                          + int'($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    task automatic add_row(input logic [etx_pkg::TC_W-1:0] terms,
                           input logic [etx_pkg::X_W-1:0] xv,
                           input logic typed, input logic [etx_pkg::EXP_W-1:0] value);
        t_vec v;
        v.terms        = terms;
        v.x            = xv;
        v.typed        = typed;
        v.want.value   = value;
        v.want.clipped = 1'b0;
        dir_table.push_back(v);
    endtask

    task automatic send_x(input logic [etx_pkg::X_W-1:0] xv, input logic typed,
                          input t_sum want);
        t_note nt;
        nt.typed = typed;
        nt.want  = want;
        sent_notes.push_back(nt);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= xv;
        do @(posedge i_clk); while (!o_s_axis_tready);
        x_sent++;
    endtask

    // sender pauses until every result is back, then writes the term count
    task automatic set_terms(input logic [etx_pkg::TC_W-1:0] n);
        i_s_axis_tvalid <= 1'b0;
        while (sums_checked < x_sent) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= n;
        term_reg = n;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // results are checked before the request of the same edge is queued
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_sum.value   = o_m_axis_tdata;
                got_sum.clipped = o_m_axis_tuser[0];
                if (pending_sums.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result %h / %b with no request waiting",
                             $time, got_sum.value, got_sum.clipped);
                end else begin
                    exp_sum = pending_sums.pop_front();
                    sums_checked++;
                    if (got_sum.value !== exp_sum.value) begin
                        fail_count++;
                        $display("%0t ns: exp_value expected %h, got %h",
                                 $time, exp_sum.value, got_sum.value);
                    end
                    if (got_sum.clipped !== exp_sum.clipped) begin
                        fail_count++;
                        $display("%0t ns: saturated expected %b, got %b",
                                 $time, exp_sum.clipped, got_sum.clipped);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (sent_notes.size() != 0) begin
                    acc_note = sent_notes.pop_front();
                    pending_sums.push_back(acc_note.typed ? acc_note.want
                                           : series_exp(i_s_axis_tdata, term_reg));
                end else begin
                    pending_sums.push_back(series_exp(i_s_axis_tdata, term_reg));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d of %0d results back", $time, sums_checked, x_sent);
            $display("exp_taylor_series_test failed");
            $finish;
        end
    end

    initial begin
        logic [etx_pkg::TC_W-1:0] tc;
        t_sum                     none;
        int                       n_table;
        none = '0;

        // x = 0 or no terms gives exactly 1.0
        add_row(5'd12, 16'h0000, 1'b1, 32'h0001_0000);
        add_row(5'd12, 16'h1000, 1'b0, '0);
        add_row(5'd12, 16'h7FFF, 1'b0, '0);
        add_row(5'd12, 16'h8000, 1'b0, '0);
        add_row(5'd12, 16'hF000, 1'b0, '0);
        add_row(5'd12, 16'h0001, 1'b0, '0);
        add_row(5'd12, 16'hFFFF, 1'b0, '0);
        add_row(5'd12, 16'h4000, 1'b0, '0);
        add_row(5'd12, 16'hC000, 1'b0, '0);
        add_row(5'd0,  16'h7FFF, 1'b1, 32'h0001_0000);
        add_row(5'd0,  16'h8000, 1'b1, 32'h0001_0000);
        add_row(5'd0,  16'h1234, 1'b1, 32'h0001_0000);
        add_row(5'd31, 16'h7FFF, 1'b0, '0);
        add_row(5'd31, 16'h8000, 1'b0, '0);
        add_row(5'd31, 16'h0000, 1'b1, 32'h0001_0000);
        add_row(5'd31, 16'h2000, 1'b0, '0);
        add_row(5'd1,  16'h7FFF, 1'b0, '0);
        add_row(5'd1,  16'h8000, 1'b0, '0);
        add_row(5'd1,  16'h1000, 1'b0, '0);
        add_row(5'd30, 16'h6000, 1'b0, '0);
        add_row(5'd2,  16'hA000, 1'b0, '0);
        add_row(5'd12, 16'h1000, 1'b0, '0);
        n_table = dir_table.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i]) begin
            if (dir_table[i].terms != term_reg)
                set_terms(dir_table[i].terms);
            send_x(dir_table[i].x, dir_table[i].typed, dir_table[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                tc = 5'd31;
            else if (p == 1)
                tc = 5'd0;
            else if (p == 2)
                tc = 5'd2;
            else if (p % 6 == 5)
                tc = etx_pkg::TC_W'($urandom_range(16, 31));
            else
                tc = etx_pkg::TC_W'($urandom_range(0, 9));
            set_terms(tc);
            hold_go <= (p == 2);
            steady  <= (p == 3 || p == 4);
            for (int i = 0; i < PER_PHASE; i++)
                send_x(rand_x(), 1'b0, none);
        end

        i_s_axis_tvalid <= 1'b0;
        steady <= 1'b0;
        while (sums_checked < x_sent) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests (%0d from the edge table), %0d results checked, %0d failures",
                 x_sent, n_table, sums_checked, fail_count);
        $display("%0d term-count writes incl. 0 and 31, one %0d-cycle receiver hold-off",
                 cfg_writes, HOLD_CYCLES);
        if (fail_count == 0 && pending_sums.size() == 0)
            $display("exp_taylor_series_test passed");
        else
            $display("exp_taylor_series_test failed");
        $finish;
    end

endmodule
